>>> hdl/sliding_window_gc_content_assert.svh
// ---------------------------------------------------------------------------
// sliding window gc content assertion macros
// property check macros, empty in synthesis
// ---------------------------------------------------------------------------
`ifndef SLIDING_WINDOW_GC_CONTENT_ASSERT_SVH
`define SLIDING_WINDOW_GC_CONTENT_ASSERT_SVH
`ifndef SYNTHESIS
`define SWGC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("swgc assertion failed");
`define SWGC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("swgc assertion failed");
`else
`define SWGC_ASSERT_IMP(lbl, ante, cons)
`define SWGC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

>>> hdl/swgc_pkg.sv
// ---------------------------------------------------------------------------
// swgc_pkg
// shared constants, codes and control types of the gc content block
// ---------------------------------------------------------------------------
package swgc_pkg;

	localparam int WINDOW_MAX = 4096;
	localparam int WIN_AW     = $clog2(WINDOW_MAX);
	localparam int WSZ_W      = 13;
	localparam int SKIP_W     = 32;
	localparam int CNT_W      = 13;
	localparam int TOT_W      = 32;
	localparam int PCT_W      = 14;
	localparam int DIV_W      = TOT_W + PCT_W;
	localparam int DIV_CW     = $clog2(DIV_W);
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DAT_W  = 32;
	localparam int OUT_DAT_W  = 128;

	localparam logic [CNT_W-1:0] CNT_MAX  = {CNT_W{1'b1}};
	localparam logic [TOT_W-1:0] TOT_MAX  = {TOT_W{1'b1}};
	localparam logic [PCT_W-1:0] PCT_FULL = PCT_W'(10000);
	localparam logic [WSZ_W-1:0] WSZ_MAX  = WSZ_W'(WINDOW_MAX);
	localparam logic [WSZ_W-1:0] WSZ_RST  = WSZ_W'(1000);
	localparam logic [SKIP_W-1:0] SKIP_RST = SKIP_W'(1000);

	localparam logic [7:0] CHAR_G_UP = 8'h47;
	localparam logic [7:0] CHAR_G_LO = 8'h67;
	localparam logic [7:0] CHAR_C_UP = 8'h43;
	localparam logic [7:0] CHAR_C_LO = 8'h63;

	localparam logic [CFG_IDX_W-1:0] REG_WINDOW_SIZE = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_SKIP_SIZE   = 1'd1;

	typedef enum logic [1:0] {
		DIV_MOD  = 2'd0,
		DIV_WPCT = 2'd1,
		DIV_TPCT = 2'd2
	} div_sel_t;

	typedef struct packed {
		logic     load;
		logic     ram_rd;
		logic     div_go;
		div_sel_t div_sel;
		logic     load_win;
		logic     load_tot;
		logic     update;
		logic     clear;
	} cmd_t;

	typedef struct packed {
		logic full;
		logic hit;
		logic last;
		logic div_done;
	} sts_t;

endpackage

>>> hdl/sliding_window_gc_content.sv
// ---------------------------------------------------------------------------
// sliding_window_gc_content
// Takes one ASCII base per item and counts G/g/C/c over a sliding window of
// window_size bases (clamped to 1..4096) and over the whole sequence. Once a
// full window is held, each new base first checks the window centre
// position; when it is a multiple of skip_size (zero acts as one) a window
// result goes out. An item with tlast set also produces an overall result
// for the sequence, after which all counts clear. Percentages are in
// hundredths of a percent, truncated. One item is handled at a time: an item
// with no full window goes through check and update only; a checked position
// adds a modulo division, and an emitted window or overall result adds a
// percentage division on the one-bit-per-cycle 46-step divider; the output
// side may stall. Configuration may only be written while the block is idle.
// ---------------------------------------------------------------------------
module sliding_window_gc_content (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [swgc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [swgc_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic                           s_axis_tvalid,
	output logic                           s_axis_tready,
	input  logic [7:0]                     s_axis_tdata,  // base
	input  logic                           s_axis_tlast,
	output logic                           m_axis_tvalid,
	input  logic                           m_axis_tready,
	// position, window_gc, total_gc, total_length, percent_x100, zero fill
	output logic [swgc_pkg::OUT_DAT_W-1:0] m_axis_tdata,
	output logic                           m_axis_tuser,  // kind
	output logic                           m_axis_tlast
);

	import swgc_pkg::*;

	cmd_t              cmd;
	sts_t              sts;
	logic              out_kind;
	logic [TOT_W-1:0]  out_position;
	logic [CNT_W-1:0]  out_window_gc;
	logic [TOT_W-1:0]  out_total_gc;
	logic [TOT_W-1:0]  out_total_length;
	logic [PCT_W-1:0]  out_percent;
	logic              out_run_last;

	swgc_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (s_axis_tvalid),
		.in_ready  (s_axis_tready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.sts       (sts),
		.cmd       (cmd)
	);

	swgc_datapath u_datapath (
		.clk              (clk),
		.arst_n           (arst_n),
		.cfg_we           (cfg_we),
		.cfg_index        (cfg_index),
		.cfg_data         (cfg_data),
		.in_base          (s_axis_tdata),
		.in_last          (s_axis_tlast),
		.cmd              (cmd),
		.sts              (sts),
		.out_kind         (out_kind),
		.out_position     (out_position),
		.out_window_gc    (out_window_gc),
		.out_total_gc     (out_total_gc),
		.out_total_length (out_total_length),
		.out_percent      (out_percent),
		.out_run_last     (out_run_last)
	);

	assign m_axis_tdata = {
		{(OUT_DAT_W - 3*TOT_W - CNT_W - PCT_W){1'b0}},
		out_percent, out_total_length, out_total_gc, out_window_gc, out_position
	};
	assign m_axis_tuser = out_kind;
	assign m_axis_tlast = out_run_last;

`include "sliding_window_gc_content_assert.svh"

	`SWGC_ASSERT_IMP(a_single_item, m_axis_tvalid, !s_axis_tready)
	`SWGC_ASSERT_NXT(a_accept_busy, s_axis_tvalid && s_axis_tready, !s_axis_tready)
	`SWGC_ASSERT_IMP(a_pct_range, m_axis_tvalid, out_percent <= PCT_FULL)
	`SWGC_ASSERT_IMP(a_total_ends, m_axis_tvalid && m_axis_tuser,
		m_axis_tlast && (out_total_length != '0))

endmodule

>>> hdl/swgc_ram.sv
// ---------------------------------------------------------------------------
// swgc_ram
// generic single write port ram with registered read
// ---------------------------------------------------------------------------
module swgc_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 4096
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> hdl/swgc_div.sv
// ---------------------------------------------------------------------------
// swgc_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
module swgc_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [swgc_pkg::DIV_W-1:0] dividend,
	input  logic [swgc_pkg::TOT_W-1:0] divisor,
	output logic                       done,
	output logic [swgc_pkg::DIV_W-1:0] quotient,
	output logic [swgc_pkg::TOT_W-1:0] remainder
);

	import swgc_pkg::*;

	logic              busy_q;
	logic              done_q;
	logic [DIV_CW-1:0] cnt_q;
	logic [DIV_W-1:0]  quo_q;
	logic [TOT_W-1:0]  rem_q;
	logic [TOT_W-1:0]  dvs_q;
	logic [TOT_W:0]    shifted;
	logic [TOT_W:0]    diff;
	logic              take;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign diff    = shifted - {1'b0, dvs_q};
	assign take    = (shifted >= {1'b0, dvs_q});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == DIV_CW'(DIV_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], take};
			rem_q <= take ? diff[TOT_W-1:0] : shifted[TOT_W-1:0];
		end
	end

	assign done      = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

>>> hdl/swgc_datapath.sv
// ---------------------------------------------------------------------------
// swgc_datapath
// config registers, counters, flag delay line, divider and result register
// ---------------------------------------------------------------------------
module swgc_datapath (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [swgc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [swgc_pkg::CFG_DAT_W-1:0] cfg_data,
	input  logic [7:0]                     in_base,
	input  logic                           in_last,
	input  swgc_pkg::cmd_t                 cmd,
	output swgc_pkg::sts_t                 sts,
	output logic                           out_kind,
	output logic [swgc_pkg::TOT_W-1:0]     out_position,
	output logic [swgc_pkg::CNT_W-1:0]     out_window_gc,
	output logic [swgc_pkg::TOT_W-1:0]     out_total_gc,
	output logic [swgc_pkg::TOT_W-1:0]     out_total_length,
	output logic [swgc_pkg::PCT_W-1:0]     out_percent,
	output logic                           out_run_last
);

	import swgc_pkg::*;

	logic [WSZ_W-1:0]  wsz_q;
	logic [SKIP_W-1:0] skip_q;
	logic [WIN_AW-1:0] wr_slot_q;
	logic [CNT_W-1:0]  win_cnt_q;
	logic [TOT_W-1:0]  tot_q;
	logic [TOT_W-1:0]  idx_q;
	logic              gc_q;
	logic              last_q;

	logic              kind_q;
	logic [TOT_W-1:0]  pos_q;
	logic [CNT_W-1:0]  wgc_q;
	logic [TOT_W-1:0]  tgc_q;
	logic [TOT_W-1:0]  len_q;
	logic [PCT_W-1:0]  pct_q;
	logic              run_last_q;

	logic [WSZ_W-1:0]  weff;
	logic [WSZ_W-1:0]  half;
	logic [TOT_W-1:0]  pos;
	logic [SKIP_W-1:0] skip_eff;
	logic [WIN_AW-1:0] rd_slot;
	logic              flag_rd;
	logic              in_gc;
	logic [TOT_W-1:0]  mul_a;
	logic [DIV_W-1:0]  product;
	logic [DIV_W-1:0]  div_dividend;
	logic [TOT_W-1:0]  div_divisor;
	logic              div_done;
	logic [DIV_W-1:0]  div_quo;
	logic [TOT_W-1:0]  div_rem;
	logic [PCT_W-1:0]  pct_sat;
	logic              dec;
	logic [CNT_W-1:0]  cnt_dec;
	logic [CNT_W-1:0]  cnt_next;

	assign in_gc = (in_base == CHAR_G_UP) || (in_base == CHAR_G_LO) ||
		(in_base == CHAR_C_UP) || (in_base == CHAR_C_LO);

	assign weff     = (wsz_q == '0) ? WSZ_W'(1) : ((wsz_q > WSZ_MAX) ? WSZ_MAX : wsz_q);
	assign half     = (weff - 1'b1) >> 1;
	assign pos      = idx_q - TOT_W'(1) - TOT_W'(half);
	assign skip_eff = (skip_q == '0) ? SKIP_W'(1) : skip_q;
	assign rd_slot  = wr_slot_q - weff[WIN_AW-1:0];

	// multiply feeds the divider's load register
	assign mul_a   = (cmd.div_sel == DIV_WPCT) ? TOT_W'(win_cnt_q) : tot_q;
	assign product = {{PCT_W{1'b0}}, mul_a} * {{TOT_W{1'b0}}, PCT_FULL};

	always_comb begin
		case (cmd.div_sel)
			DIV_MOD: begin
				div_dividend = DIV_W'(pos);
				div_divisor  = skip_eff;
			end
			DIV_WPCT: begin
				div_dividend = product;
				div_divisor  = TOT_W'(weff);
			end
			DIV_TPCT: begin
				div_dividend = product;
				div_divisor  = idx_q;
			end
			default: begin
				div_dividend = '0;
				div_divisor  = skip_eff;
			end
		endcase
	end

	swgc_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_go),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.done      (div_done),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	swgc_ram #(
		.WIDTH (1),
		.DEPTH (WINDOW_MAX)
	) u_flag_line (
		.clk   (clk),
		.we    (cmd.update),
		.waddr (wr_slot_q),
		.wdata (gc_q),
		.re    (cmd.ram_rd),
		.raddr (rd_slot),
		.rdata (flag_rd)
	);

	assign pct_sat = (div_quo > DIV_W'(PCT_FULL)) ? PCT_FULL : div_quo[PCT_W-1:0];

	assign sts.full     = (idx_q >= TOT_W'(weff));
	assign sts.hit      = (div_rem == '0);
	assign sts.last     = last_q;
	assign sts.div_done = div_done;

	// oldest flag leaves before the new one enters
	assign dec      = sts.full && flag_rd && (win_cnt_q != '0);
	assign cnt_dec  = dec ? (win_cnt_q - 1'b1) : win_cnt_q;
	assign cnt_next = (gc_q && (cnt_dec != CNT_MAX)) ? (cnt_dec + 1'b1) : cnt_dec;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wsz_q     <= WSZ_RST;
			skip_q    <= SKIP_RST;
			wr_slot_q <= '0;
			win_cnt_q <= '0;
			tot_q     <= '0;
			idx_q     <= '0;
			last_q    <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_WINDOW_SIZE: wsz_q  <= cfg_data[WSZ_W-1:0];
					REG_SKIP_SIZE:   skip_q <= cfg_data[SKIP_W-1:0];
					default: ;
				endcase
			end
			if (cmd.load) begin
				last_q <= in_last;
			end
			if (cmd.update) begin
				wr_slot_q <= wr_slot_q + 1'b1;
				win_cnt_q <= cnt_next;
				if (gc_q && (tot_q != TOT_MAX)) begin
					tot_q <= tot_q + 1'b1;
				end
				if (idx_q != TOT_MAX) begin
					idx_q <= idx_q + 1'b1;
				end
			end
			if (cmd.clear) begin
				wr_slot_q <= '0;
				win_cnt_q <= '0;
				tot_q     <= '0;
				idx_q     <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			gc_q <= in_gc;
		end
		if (cmd.load_win) begin
			kind_q     <= 1'b0;
			pos_q      <= pos;
			wgc_q      <= win_cnt_q;
			tgc_q      <= '0;
			len_q      <= '0;
			pct_q      <= pct_sat;
			run_last_q <= !last_q;
		end else if (cmd.load_tot) begin
			kind_q     <= 1'b1;
			pos_q      <= '0;
			wgc_q      <= '0;
			tgc_q      <= tot_q;
			len_q      <= idx_q;
			pct_q      <= pct_sat;
			run_last_q <= 1'b1;
		end
	end

	assign out_kind         = kind_q;
	assign out_position     = pos_q;
	assign out_window_gc    = wgc_q;
	assign out_total_gc     = tgc_q;
	assign out_total_length = len_q;
	assign out_percent      = pct_q;
	assign out_run_last     = run_last_q;

endmodule

>>> hdl/swgc_ctrl.sv
// ---------------------------------------------------------------------------
// swgc_ctrl
// sequencer for one item: window check, divisions, result hand-off, update
// ---------------------------------------------------------------------------
module swgc_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  logic           out_ready,
	input  swgc_pkg::sts_t sts,
	output swgc_pkg::cmd_t cmd
);

	import swgc_pkg::*;

	typedef enum logic [8:0] {
		ST_IDLE   = 9'b000000001,
		ST_CHECK  = 9'b000000010,
		ST_MOD    = 9'b000000100,
		ST_WPCT   = 9'b000001000,
		ST_WOUT   = 9'b000010000,
		ST_UPDATE = 9'b000100000,
		ST_TSTART = 9'b001000000,
		ST_TPCT   = 9'b010000000,
		ST_TOUT   = 9'b100000000
	} state_t;

	state_t state_q;
	state_t state_nxt;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_WOUT) || (state_q == ST_TOUT);

	always_comb begin
		state_nxt   = state_q;
		cmd         = '0;
		cmd.div_sel = DIV_MOD;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.load  = 1'b1;
					state_nxt = ST_CHECK;
				end
			end
			ST_CHECK: begin
				if (sts.full) begin
					cmd.ram_rd = 1'b1;
					cmd.div_go = 1'b1;
					state_nxt  = ST_MOD;
				end else begin
					state_nxt = ST_UPDATE;
				end
			end
			ST_MOD: begin
				if (sts.div_done) begin
					if (sts.hit) begin
						cmd.div_go  = 1'b1;
						cmd.div_sel = DIV_WPCT;
						state_nxt   = ST_WPCT;
					end else begin
						state_nxt = ST_UPDATE;
					end
				end
			end
			ST_WPCT: begin
				if (sts.div_done) begin
					cmd.load_win = 1'b1;
					state_nxt    = ST_WOUT;
				end
			end
			ST_WOUT: begin
				if (out_ready) begin
					state_nxt = ST_UPDATE;
				end
			end
			ST_UPDATE: begin
				cmd.update = 1'b1;
				state_nxt  = sts.last ? ST_TSTART : ST_IDLE;
			end
			ST_TSTART: begin
				cmd.div_go  = 1'b1;
				cmd.div_sel = DIV_TPCT;
				state_nxt   = ST_TPCT;
			end
			ST_TPCT: begin
				cmd.div_sel = DIV_TPCT;
				if (sts.div_done) begin
					cmd.load_tot = 1'b1;
					state_nxt    = ST_TOUT;
				end
			end
			ST_TOUT: begin
				if (out_ready) begin
					cmd.clear = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

>>> test/tb_top.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_top
// Checks sliding_window_gc_content end to end. A directed table covers reset
// settings, extreme bytes, every gc letter, clamped window and skip values and
// short sequences. Random phases with mixed windows and skips follow, some
// changing the window inside a sequence. Every result is compared with the
// table value or with a gc window and sequence total model kept in the bench.
// ---------------------------------------------------------------------------
module tb_top;

	import swgc_pkg::*;

	localparam logic KIND_WINDOW = 1'b0;
	localparam logic KIND_TOTAL  = 1'b1;
	localparam int   RANDOM_ITEMS = 1280;
	localparam int   SETTLE_CYCLES = 150;

	typedef struct packed {
		logic        kind;
		logic [31:0] position;
		logic [12:0] window_gc;
		logic [31:0] total_gc;
		logic [31:0] total_length;
		logic [13:0] percent;
		logic        run_last;
	} gc_result_t;

	typedef struct packed {
		logic [7:0]  base;
		logic        last;
		logic        reconfig;
		logic [12:0] win;
		logic [31:0] skip;
		logic        typed;
		logic        has_res;
		gc_result_t  res;
	} stim_row_t;

	logic                 clk;
	logic                 arst_n;
	logic                 cfg_we;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [CFG_DAT_W-1:0] cfg_data;
	logic                 s_axis_tvalid;
	logic                 s_axis_tready;
	logic [7:0]           s_axis_tdata;
	logic                 s_axis_tlast;
	logic                 m_axis_tvalid;
	logic                 m_axis_tready;
	logic [OUT_DAT_W-1:0] m_axis_tdata;
	logic                 m_axis_tuser;
	logic                 m_axis_tlast;

	sliding_window_gc_content u_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tuser  (m_axis_tuser),
		.m_axis_tlast  (m_axis_tlast)
	);

	// model state
	logic [12:0]  win_reg;
	logic [31:0]  skip_reg;
	logic         gc_flags [0:WINDOW_MAX-1];
	int unsigned  fill_slot;
	int unsigned  win_gc_cnt;
	logic [31:0]  seq_gc_cnt;
	logic [31:0]  seq_len;

	gc_result_t   expected_q[$];
	stim_row_t    stim_rows[$];
	int           errors;
	int           burst_left;
	bit           gap_free;

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	initial begin
		#40_000_000;
		$display("[sliding_window_gc_content] ERROR");
		$finish;
	end

	function automatic gc_result_t total_res(input logic [31:0] gc, input logic [31:0] len,
		input logic [13:0] pct);
		gc_result_t r;
		r = '0;
		r.kind = KIND_TOTAL;
		r.total_gc = gc;
		r.total_length = len;
		r.percent = pct;
		r.run_last = 1'b1;
		return r;
	endfunction

	function automatic stim_row_t row(input logic [7:0] b, input logic l, input logic typed,
		input logic has_res, input gc_result_t res);
		stim_row_t s;
		s = '0;
		s.base = b;
		s.last = l;
		s.typed = typed;
		s.has_res = has_res;
		s.res = res;
		return s;
	endfunction

	function automatic stim_row_t cfg_row(input logic [12:0] w, input logic [31:0] sk,
		input logic [7:0] b, input logic l);
		stim_row_t s;
		s = row(b, l, 1'b0, 1'b0, '0);
		s.reconfig = 1'b1;
		s.win = w;
		s.skip = sk;
		return s;
	endfunction

	function automatic logic [7:0] pick_base();
		logic [7:0] b;
		case ($urandom_range(0, 9))
			0: b = 8'($urandom);
			1, 2: b = CHAR_G_UP;
			3: b = CHAR_G_LO;
			4, 5: b = CHAR_C_UP;
			6: b = CHAR_C_LO;
			7: b = "A";
			8: b = "t";
			default: b = "T";
		endcase
		return b;
	endfunction

	task automatic clear_seq();
		fill_slot = 0;
		win_gc_cnt = 0;
		seq_gc_cnt = '0;
		seq_len = '0;
	endtask

	// window and sequence totals for one base; results go to expected_q when keep is set
	task automatic predict_gc(input logic [7:0] b, input logic l, input bit keep);
		int unsigned     w;
		int unsigned     pos;
		int unsigned     sk;
		int unsigned     rd;
		longint unsigned pct;
		logic            gc;
		gc_result_t      r;
		w = (win_reg == 0) ? 1 : ((win_reg > WSZ_MAX) ? WINDOW_MAX : 32'(win_reg));
		gc = (b == CHAR_G_UP) || (b == CHAR_G_LO) || (b == CHAR_C_UP) || (b == CHAR_C_LO);
		if (seq_len >= w) begin
			pos = (seq_len - 1) - (w - 1) / 2;
			sk = (skip_reg == 0) ? 1 : skip_reg;
			rd = (fill_slot + WINDOW_MAX - w) % WINDOW_MAX;
			if (pos % sk == 0) begin
				pct = 64'(win_gc_cnt) * 64'd10000 / 64'(w);
				if (pct > 10000) pct = 10000;
				r = '0;
				r.kind = KIND_WINDOW;
				r.position = pos;
				r.window_gc = 13'(win_gc_cnt);
				r.percent = 14'(pct);
				r.run_last = !l;
				if (keep) expected_q.push_back(r);
			end
			if (gc_flags[WIN_AW'(rd)] && win_gc_cnt > 0) win_gc_cnt--;
		end
		gc_flags[WIN_AW'(fill_slot)] = gc;
		fill_slot = (fill_slot + 1) % WINDOW_MAX;
		if (gc) begin
			if (win_gc_cnt < 8191) win_gc_cnt++;
			if (seq_gc_cnt != TOT_MAX) seq_gc_cnt++;
		end
		if (seq_len != TOT_MAX) seq_len++;
		if (l) begin
			pct = 64'(seq_gc_cnt) * 64'd10000 / 64'(seq_len);
			if (pct > 10000) pct = 10000;
			if (keep) expected_q.push_back(total_res(seq_gc_cnt, seq_len, 14'(pct)));
			clear_seq();
		end
	endtask

	task automatic send_base(input logic [7:0] b, input logic l, input bit keep);
		int gap;
		if (burst_left <= 0) begin
			burst_left = $urandom_range(1, 16);
			if (!gap_free) begin
				gap = $urandom_range(1, 8);
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= b;
		s_axis_tlast <= l;
		do @(posedge clk); while (!s_axis_tready);
		burst_left--;
		predict_gc(b, l, keep);
	endtask

	task automatic drain();
		s_axis_tvalid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic set_config(input logic [12:0] w, input logic [31:0] sk);
		cfg_we <= 1'b1;
		cfg_index <= REG_WINDOW_SIZE;
		cfg_data <= {19'($urandom), w};
		@(posedge clk);
		cfg_index <= REG_SKIP_SIZE;
		cfg_data <= sk;
		@(posedge clk);
		cfg_we <= 1'b0;
		win_reg = w;
		skip_reg = sk;
	endtask

	task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] a);
		if (a !== e) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, e, a);
			errors++;
		end
	endtask

	// result side: checks and stalls
	initial begin
		gc_result_t  act;
		gc_result_t  e;
		int          stall_left;
		int          stall_mode;
		int unsigned cyc;
		m_axis_tready = 1'b0;
		stall_left = 0;
		stall_mode = 0;
		cyc = 0;
		forever begin
			@(posedge clk);
			if (arst_n && m_axis_tvalid && m_axis_tready) begin
				act.kind = m_axis_tuser;
				act.position = m_axis_tdata[31:0];
				act.window_gc = m_axis_tdata[44:32];
				act.total_gc = m_axis_tdata[76:45];
				act.total_length = m_axis_tdata[108:77];
				act.percent = m_axis_tdata[122:109];
				act.run_last = m_axis_tlast;
				if (expected_q.size() == 0) begin
					$display("%0t: unexpected item, expected none, got %h", $time, act);
					errors++;
				end else begin
					e = expected_q.pop_front();
					check_field("kind", 32'(e.kind), 32'(act.kind));
					check_field("position", e.position, act.position);
					check_field("window_gc", 32'(e.window_gc), 32'(act.window_gc));
					check_field("total_gc", e.total_gc, act.total_gc);
					check_field("total_length", e.total_length, act.total_length);
					check_field("percent_x100", 32'(e.percent), 32'(act.percent));
					check_field("run_last", 32'(e.run_last), 32'(act.run_last));
				end
			end
			if (stall_left <= 0) begin
				stall_mode = $urandom_range(0, 3);
				stall_left = $urandom_range(20, 200);
			end
			stall_left--;
			cyc++;
			case (stall_mode)
				0: m_axis_tready <= 1'b1;
				1: m_axis_tready <= ($urandom_range(0, 3) != 0);
				2: m_axis_tready <= ((cyc % 5) < 2);
				default: m_axis_tready <= ($urandom_range(0, 7) == 0);
			endcase
		end
	end

	initial begin
		stim_row_t   r;
		int          rnd_items;
		int          seq_left;
		int          phase_left;
		int          w_eff;
		logic [12:0] wv;
		logic [31:0] sv;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tlast = 1'b0;
		errors = 0;
		burst_left = 0;
		gap_free = 1'b0;
		win_reg = WSZ_RST;
		skip_reg = SKIP_RST;
		clear_seq();

		// reset settings, short sequences
		stim_rows.push_back(row(CHAR_G_UP, 1'b1, 1'b1, 1'b1,
			total_res(32'd1, 32'd1, 14'd10000)));
		stim_rows.push_back(row(8'h00, 1'b1, 1'b1, 1'b1, total_res(32'd0, 32'd1, 14'd0)));
		stim_rows.push_back(row(8'hFF, 1'b1, 1'b1, 1'b1, total_res(32'd0, 32'd1, 14'd0)));
		stim_rows.push_back(row(CHAR_G_LO, 1'b0, 1'b1, 1'b0, '0));
		stim_rows.push_back(row(CHAR_C_UP, 1'b0, 1'b1, 1'b0, '0));
		stim_rows.push_back(row(CHAR_C_LO, 1'b0, 1'b1, 1'b0, '0));
		stim_rows.push_back(row("A", 1'b1, 1'b1, 1'b1, total_res(32'd3, 32'd4, 14'd7500)));
		// window zero clamps to one, skip zero acts as one
		stim_rows.push_back(cfg_row(13'd0, 32'd0, CHAR_C_LO, 1'b1));
		stim_rows.push_back(row("T", 1'b0, 1'b0, 1'b0, '0));
		stim_rows.push_back(row(CHAR_G_UP, 1'b0, 1'b0, 1'b0, '0));
		stim_rows.push_back(row("x", 1'b1, 1'b0, 1'b0, '0));
		stim_rows.push_back(cfg_row(13'd4, 32'd2, CHAR_G_UP, 1'b0));
		stim_rows.push_back(row(CHAR_C_UP, 1'b0, 1'b0, 1'b0, '0));
		stim_rows.push_back(row("a", 1'b0, 1'b0, 1'b0, '0));
		stim_rows.push_back(row("t", 1'b0, 1'b0, 1'b0, '0));
		stim_rows.push_back(row(CHAR_G_LO, 1'b0, 1'b0, 1'b0, '0));
		stim_rows.push_back(row(CHAR_C_LO, 1'b0, 1'b0, 1'b0, '0));
		stim_rows.push_back(row(CHAR_G_UP, 1'b0, 1'b0, 1'b0, '0));
		stim_rows.push_back(row("N", 1'b1, 1'b0, 1'b0, '0));
		// largest window and skip, sequence too short for a window
		stim_rows.push_back(cfg_row(WSZ_MAX, 32'hFFFF_FFFF, CHAR_G_LO, 1'b0));
		stim_rows.push_back(row("a", 1'b1, 1'b0, 1'b0, '0));
		stim_rows.push_back(cfg_row(13'h1FFF, 32'd1, CHAR_C_UP, 1'b1));

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (stim_rows[i]) begin
			r = stim_rows[i];
			if (r.reconfig) begin
				drain();
				set_config(r.win, r.skip);
			end
			send_base(r.base, r.last, !r.typed);
			if (r.typed && r.has_res) expected_q.push_back(r.res);
		end

		// random phases; sequences may run across a setting change
		rnd_items = 0;
		seq_left = 0;
		while (rnd_items < RANDOM_ITEMS) begin
			drain();
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: wv = 13'($urandom_range(1, 8));
				6, 7: wv = 13'($urandom_range(9, 40));
				8: wv = 13'd0;
				default: wv = 13'($urandom_range(WINDOW_MAX, 8191));
			endcase
			case ($urandom_range(0, 9))
				0: sv = 32'd0;
				1, 9: sv = 32'd1;
				2, 3, 4, 5: sv = $urandom_range(2, 5);
				6: sv = $urandom_range(6, 20);
				7: sv = 32'hFFFF_FFFF;
				default: sv = $urandom;
			endcase
			set_config(wv, sv);
			w_eff = (wv == 0) ? 1 : ((wv > WSZ_MAX) ? WINDOW_MAX : int'(wv));
			phase_left = (w_eff > 64) ? 30 : $urandom_range(40, 120);
			gap_free = ($urandom_range(0, 3) == 0);
			while (phase_left > 0) begin
				if (seq_left == 0)
					seq_left = (w_eff > 64) ? $urandom_range(1, 30) : $urandom_range(1, 3 * w_eff + 12);
				send_base(pick_base(), seq_left == 1, 1'b1);
				seq_left--;
				phase_left--;
				rnd_items++;
			end
		end
		while (seq_left > 0) begin
			send_base(pick_base(), seq_left == 1, 1'b1);
			seq_left--;
		end

		drain();
		if (errors == 0) begin
			$display("[sliding_window_gc_content] OK");
		end else begin
			$display("[sliding_window_gc_content] ERROR");
		end
		$finish;
	end

endmodule
